@@ rtl/qse_pkg.sv @@
// qse_pkg: shared types and constants for the quicksort engine
// no dependencies; used by qse_range_stack and quicksort_engine
package qse_pkg;

  localparam int DATA_W = 32;

  // control from the sort sequencer to the range stack
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  // status returned by the range stack
  typedef struct packed {
    logic empty;
  } stk_stat_t;

endpackage

@@ rtl/qse_range_stack.sv @@
// qse_range_stack: memory-backed stack of pending (low, high) index ranges
// depends on qse_pkg for the control and status structs
module qse_range_stack #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qse_pkg::stk_ctl_t   ctl,
  input  logic [IW-1:0]       push_lo,
  input  logic [IW-1:0]       push_hi,
  output logic [IW-1:0]       pop_lo,
  output logic [IW-1:0]       pop_hi,
  output qse_pkg::stk_stat_t  stat
);
  import qse_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SPW = AW + 1;

  logic [2*IW-1:0] mem [DEPTH];
  logic [2*IW-1:0] rd_r;
  logic [SPW-1:0]  sp_r;
  logic [SPW-1:0]  sp_nxt;
  logic [SPW-1:0]  sp_dec;
  logic            do_push;
  logic            do_pop;

  assign sp_dec  = sp_r - SPW'(1);
  assign do_push = ctl.push && (sp_r < SPW'(DEPTH));
  assign do_pop  = ctl.pop && (sp_r != '0);

  always_comb begin
    sp_nxt = sp_r;
    if (do_push) begin
      sp_nxt = sp_r + SPW'(1);
    end else if (do_pop) begin
      sp_nxt = sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[sp_r[AW-1:0]] <= {push_lo, push_hi};
    end
    if (do_pop) begin
      rd_r <= mem[sp_dec[AW-1:0]];
    end
  end

  assign pop_lo     = rd_r[2*IW-1:IW];
  assign pop_hi     = rd_r[IW-1:0];
  assign stat.empty = (sp_r == '0);

endmodule

@@ rtl/quicksort_engine.sv @@
// quicksort_engine: collects signed words, sorts them with a lomuto quicksort
// depends on qse_pkg and qse_range_stack
//
//  channel   | ports                         | content
//  ----------+-------------------------------+---------------------------------
//  input     | in_tvalid/in_tready/in_tdata  | value[31:0]; in_tlast ends a set
//  output    | out_tvalid/out_tready/out_tdata | sorted_value[31:0]; out_tlast
//
// loading takes one word per cycle; the MAX_ELEMENTS-th word closes the set
// sorting runs on the single read port of the element memory: a scan step
// fetches, compares and may swap; pop/range/pivot open a range, place/push end it
// output goes one word per cycle after a registered fetch; out_tready low holds it
// no word is accepted while sorting or emitting; rst_n (sync, low) empties it
module quicksort_engine #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [qse_pkg::DATA_W-1:0] in_tdata,   // [31:0] value
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [qse_pkg::DATA_W-1:0] out_tdata,  // [31:0] sorted_value
  output logic                       out_tlast
);
  import qse_pkg::*;

  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = IW + 1;

  typedef enum logic [3:0] {
    ST_LOAD,     // accepting words
    ST_POP,      // take next pending range, or start output
    ST_RANGE,    // range arrives from the stack, fetch pivot
    ST_PIVOT,    // latch pivot
    ST_SCAN,     // fetch element j
    ST_CMP,      // compare element j against pivot
    ST_SWAP_A,   // write old element i to j
    ST_SWAP_B,   // write old element j to i
    ST_PLACE,    // fetch element i for the pivot swap
    ST_PLACE_A,  // element i goes to hi
    ST_PLACE_B,  // pivot goes to i
    ST_PUSH_R,   // push upper part
    ST_PUSH_L,   // push lower part
    ST_EMIT      // present sorted words
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;      // words in the current set
  logic [IW-1:0]         lo_r, lo_nxt;
  logic [IW-1:0]         hi_r, hi_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic [IW-1:0]         j_r, j_nxt;          // scan index, also output index
  logic signed [DATA_W-1:0] pivot_r, pivot_nxt;
  logic [DATA_W-1:0]     tmp_r, tmp_nxt;      // element j held across a swap

  // element memory port
  logic [DATA_W-1:0]     em [MAX_ELEMENTS];
  logic                  em_we, em_re;
  logic [IW-1:0]         em_wa, em_ra;
  logic [DATA_W-1:0]     em_wd;
  logic [DATA_W-1:0]     em_rd_r;

  // range stack
  stk_ctl_t              stk_ctl;
  stk_stat_t             stk_stat;
  logic [IW-1:0]         push_lo, push_hi, pop_lo, pop_hi;

  logic                  in_acc, out_acc, set_done, is_last;

  qse_range_stack #(
    .DEPTH (MAX_ELEMENTS),
    .IW    (IW)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (stk_ctl),
    .push_lo (push_lo),
    .push_hi (push_hi),
    .pop_lo  (pop_lo),
    .pop_hi  (pop_hi),
    .stat    (stk_stat)
  );

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = em_rd_r;
  assign is_last    = ({1'b0, j_r} == (cnt_r - CW'(1)));
  assign out_tlast  = is_last;
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  // a full memory closes the set whatever tlast says
  assign set_done   = in_tlast || (cnt_r == CW'(MAX_ELEMENTS - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pivot_nxt = pivot_r;
    tmp_nxt   = tmp_r;
    em_we     = 1'b0;
    em_wa     = i_r;
    em_wd     = tmp_r;
    em_re     = 1'b0;
    em_ra     = j_r;
    stk_ctl   = '0;
    push_lo   = lo_r;
    push_hi   = hi_r;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          em_we   = 1'b1;
          em_wa   = cnt_r[IW-1:0];
          em_wd   = in_tdata;
          cnt_nxt = cnt_r + CW'(1);
          if (set_done) begin
            // whole set as first range when it holds two or more words
            if (cnt_r != '0) begin
              stk_ctl.push = 1'b1;
              push_lo      = '0;
              push_hi      = cnt_r[IW-1:0];
            end
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (stk_stat.empty) begin
          em_re     = 1'b1;
          em_ra     = '0;
          j_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          stk_ctl.pop = 1'b1;
          state_nxt   = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (pop_lo >= pop_hi) begin
          state_nxt = ST_POP;
        end else begin
          lo_nxt    = pop_lo;
          hi_nxt    = pop_hi;
          i_nxt     = pop_lo;
          j_nxt     = pop_lo;
          em_re     = 1'b1;
          em_ra     = pop_hi;
          state_nxt = ST_PIVOT;
        end
      end
      ST_PIVOT: begin
        pivot_nxt = $signed(em_rd_r);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (j_r == hi_r) begin
          state_nxt = ST_PLACE;
        end else begin
          em_re     = 1'b1;
          em_ra     = j_r;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if ($signed(em_rd_r) <= pivot_r) begin
          if (i_r == j_r) begin
            i_nxt     = i_r + IW'(1);
            j_nxt     = j_r + IW'(1);
            state_nxt = ST_SCAN;
          end else begin
            tmp_nxt   = em_rd_r;
            em_re     = 1'b1;
            em_ra     = i_r;
            state_nxt = ST_SWAP_A;
          end
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_SWAP_A: begin
        em_we     = 1'b1;
        em_wa     = j_r;
        em_wd     = em_rd_r;
        state_nxt = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        em_we     = 1'b1;
        em_wa     = i_r;
        em_wd     = tmp_r;
        i_nxt     = i_r + IW'(1);
        j_nxt     = j_r + IW'(1);
        state_nxt = ST_SCAN;
      end
      ST_PLACE: begin
        if (i_r == hi_r) begin
          state_nxt = ST_PUSH_R;
        end else begin
          em_re     = 1'b1;
          em_ra     = i_r;
          state_nxt = ST_PLACE_A;
        end
      end
      ST_PLACE_A: begin
        em_we     = 1'b1;
        em_wa     = hi_r;
        em_wd     = em_rd_r;
        state_nxt = ST_PLACE_B;
      end
      ST_PLACE_B: begin
        em_we     = 1'b1;
        em_wa     = i_r;
        em_wd     = pivot_r;
        state_nxt = ST_PUSH_R;
      end
      ST_PUSH_R: begin
        if ({1'b0, hi_r} > ({1'b0, i_r} + CW'(1))) begin
          stk_ctl.push = 1'b1;
          push_lo      = i_r + IW'(1);
          push_hi      = hi_r;
        end
        state_nxt = ST_PUSH_L;
      end
      ST_PUSH_L: begin
        if ({1'b0, i_r} > ({1'b0, lo_r} + CW'(1))) begin
          stk_ctl.push = 1'b1;
          push_lo      = lo_r;
          push_hi      = i_r - IW'(1);
        end
        state_nxt = ST_POP;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (is_last) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            // fetch the next word so it shows the following cycle
            j_nxt = j_r + IW'(1);
            em_re = 1'b1;
            em_ra = j_r + IW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    pivot_r <= pivot_nxt;
    tmp_r   <= tmp_nxt;
  end

  // element memory; reads and writes to one entry never share a cycle
  always_ff @(posedge clk) begin
    if (em_we) begin
      em[em_wa] <= em_wd;
    end
    if (em_re) begin
      em_rd_r <= em[em_ra];
    end
  end

  // the two channels never run at once
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output active together");

  // the last sorted word reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && cnt_r == '0))
    else $error("input not reopened after last word");

  // lomuto invariant: i never passes j while a range is scanned
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_CMP) |-> (i_r <= j_r && j_r <= hi_r))
    else $error("scan indices out of order");

  // a set never overfills the element memory
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ELEMENTS))
    else $error("element count overflow");

endmodule
